@@ rtl/clnws_pkg.sv @@
// Shared types, codes and constants for the character LCD nibble write sequencer.
package clnws_pkg;

  // Request kind codes as they arrive on the input channel
  localparam logic [2:0] KIND_CMD    = 3'd0;
  localparam logic [2:0] KIND_CHAR   = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_NUMBER = 3'd3;
  localparam logic [2:0] KIND_INIT   = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;

  // Bus constants
  localparam logic [7:0]  LINE0_BASE   = 8'h80;
  localparam logic [7:0]  LINE1_BASE   = 8'hC0;
  localparam logic [7:0]  CMD_FUNCSET  = 8'h28;
  localparam logic [7:0]  CMD_DISPON   = 8'h0C;
  localparam logic [7:0]  CMD_CLEAR    = 8'h01;
  localparam logic [3:0]  INIT_NIB_A   = 4'h3;
  localparam logic [3:0]  INIT_NIB_B   = 4'h2;
  localparam logic [7:0]  ASCII_ZERO   = 8'd48;
  localparam logic [12:0] WAIT_LONG_US = 13'd5000;
  localparam logic [12:0] WAIT_CHAR_US = 13'd5;
  localparam logic [12:0] WAIT_INIT_US = 13'd10;
  localparam logic [12:0] WAIT_NONE_US = 13'd0;

  // Digit count saturation and decimal storage (a 32-bit value has ten digits)
  localparam logic [4:0] MAX_DIGITS  = 5'd20;
  localparam int         BCD_DIGITS  = 10;
  localparam int         BCD_W       = 4 * BCD_DIGITS;
  localparam int         BIN_W       = 32;
  localparam int         STEP_W      = 6;
  localparam logic [STEP_W-1:0] INIT_XFERS = 6'd8;
  localparam logic [STEP_W-1:0] BYTE_XFERS = 6'd2;

  // Operation carried from the front to the back
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_NUMBER,
    OP_INIT
  } op_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_e;

  // One classified request
  typedef struct packed {
    op_e              op;
    logic             rs;
    logic [7:0]       data;
    logic [12:0]      wait_before;
    logic [12:0]      wait_after;
    logic [BCD_W-1:0] bcd;
    logic [4:0]       count;
  } entry_t;

  // One nibble transfer
  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [12:0] wait_before;
    logic [12:0] wait_after;
  } xfer_t;

  // Fixed init sequence, eight transfers
  function automatic xfer_t init_xfer(input logic [2:0] idx);
    xfer_t x;
    x.rs          = 1'b0;
    x.wait_before = WAIT_NONE_US;
    x.wait_after  = WAIT_NONE_US;
    case (idx)
      3'd0: begin
        x.nib        = INIT_NIB_A;
        x.wait_after = WAIT_INIT_US;
      end
      3'd1: begin
        x.nib        = INIT_NIB_B;
        x.wait_after = WAIT_INIT_US;
      end
      3'd2: x.nib = CMD_FUNCSET[7:4];
      3'd3: x.nib = CMD_FUNCSET[3:0];
      3'd4: x.nib = CMD_DISPON[7:4];
      3'd5: x.nib = CMD_DISPON[3:0];
      3'd6: x.nib = CMD_CLEAR[7:4];
      default: begin
        x.nib        = CMD_CLEAR[3:0];
        x.wait_after = WAIT_LONG_US;
      end
    endcase
    return x;
  endfunction

endpackage

@@ rtl/clnws_front.sv @@
// Front end: accepts requests, classifies them and converts numbers to decimal.
module clnws_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           kind_i,
  input  logic [7:0]           value_i,
  input  logic [5:0]           column_i,
  input  logic                 row_i,
  input  logic [31:0]          number_i,
  input  logic [4:0]           digit_count_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output clnws_pkg::entry_t    push_entry_o
);
  import clnws_pkg::*;

  front_state_e     state_q, state_d;
  entry_t           entry_q, entry_d;
  logic [BIN_W-1:0] bin_q, bin_d;
  logic [4:0]       iter_q, iter_d;
  logic [BCD_W-1:0] bcd_adj;
  logic [7:0]       line_base;

  // Double-dabble step: add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (entry_q.bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = entry_q.bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = entry_q.bcd[4*i +: 4];
      end
    end
  end

  assign line_base = row_i ? LINE1_BASE : LINE0_BASE;

  // Next state and classification
  always_comb begin
    state_d = state_q;
    entry_d = entry_q;
    bin_d   = bin_q;
    iter_d  = iter_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          entry_d.op          = OP_BYTE;
          entry_d.rs          = 1'b0;
          entry_d.data        = value_i;
          entry_d.wait_before = WAIT_NONE_US;
          entry_d.wait_after  = WAIT_NONE_US;
          entry_d.bcd         = '0;
          entry_d.count       = (digit_count_i > MAX_DIGITS) ? MAX_DIGITS : digit_count_i;
          bin_d               = number_i;
          iter_d              = '0;
          case (kind_i)
            KIND_CMD: state_d = F_PUSH;
            KIND_CHAR: begin
              entry_d.rs         = 1'b1;
              entry_d.wait_after = WAIT_CHAR_US;
              state_d            = F_PUSH;
            end
            KIND_CURSOR: begin
              entry_d.data        = line_base + {2'b00, column_i};
              entry_d.wait_before = WAIT_LONG_US;
              state_d             = F_PUSH;
            end
            KIND_NUMBER: begin
              entry_d.op = OP_NUMBER;
              entry_d.rs = 1'b1;
              if (digit_count_i != 5'd0) begin
                state_d = F_CONV;
              end
            end
            KIND_INIT: begin
              entry_d.op = OP_INIT;
              state_d    = F_PUSH;
            end
            KIND_CLEAR: begin
              entry_d.data       = CMD_CLEAR;
              entry_d.wait_after = WAIT_LONG_US;
              state_d            = F_PUSH;
            end
            default: state_d = F_IDLE;
          endcase
        end
      end
      F_CONV: begin
        entry_d.bcd = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
        bin_d       = {bin_q[BIN_W-2:0], 1'b0};
        iter_d      = iter_q + 5'd1;
        if (iter_q == 5'd31) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    bin_q   <= bin_d;
    iter_q  <= iter_d;
  end

  assign in_ready_o   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_entry_o = entry_q;

`ifndef NO_ASSERTIONS
  // Number requests reach the queue with a nonzero, saturated digit count
  a_num_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o && entry_q.op == OP_NUMBER |-> entry_q.count != 5'd0 &&
    entry_q.count <= MAX_DIGITS)
    else $error("number entry with bad digit count");

  // Conversion ends after the last shift
  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_CONV && iter_q == 5'd31 |=> state_q == F_PUSH)
    else $error("conversion did not finish on time");

  // A waiting entry is held until the queue takes it
  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_PUSH && !push_ready_i |=> state_q == F_PUSH && $stable(entry_q))
    else $error("pending entry changed");
`endif

endmodule

@@ rtl/clnws_queue.sv @@
// Two-entry queue of classified requests between front and back.
module clnws_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  clnws_pkg::entry_t push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output clnws_pkg::entry_t pop_entry_o
);
  import clnws_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ rtl/clnws_back.sv @@
// Back end: walks one classified request and emits its nibble transfers.
module clnws_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  clnws_pkg::entry_t pop_entry_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              register_select_o,
  output logic [3:0]        nibble_o,
  output logic [12:0]       wait_before_us_o,
  output logic [12:0]       wait_after_us_o,
  output logic              last_o
);
  import clnws_pkg::*;

  back_state_e       state_q, state_d;
  entry_t            cur_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] total;
  logic [4:0]        digit_idx;
  logic [3:0]        digit;
  logic              load;
  xfer_t             xfer, xfer_q;
  logic              xfer_last, last_q, out_valid_q;

  // Number of transfers of the current request
  always_comb begin
    case (cur_q.op)
      OP_NUMBER: total = {cur_q.count, 1'b0};
      OP_INIT:   total = INIT_XFERS;
      default:   total = BYTE_XFERS;
    endcase
  end

  // Digit for this step, most significant first; digits above the tenth are zero
  assign digit_idx = cur_q.count - 5'd1 - step_q[STEP_W-1:1];
  assign digit     = (digit_idx < 5'(BCD_DIGITS)) ? cur_q.bcd[{digit_idx[3:0], 2'b00} +: 4]
                                                 : 4'd0;

  // Transfer for the current step
  always_comb begin
    xfer.rs          = cur_q.rs;
    xfer.wait_before = WAIT_NONE_US;
    xfer.wait_after  = WAIT_NONE_US;
    case (cur_q.op)
      OP_NUMBER: begin
        xfer.nib = step_q[0] ? (ASCII_ZERO[3:0] | digit) : ASCII_ZERO[7:4];
      end
      OP_INIT: begin
        xfer = init_xfer(step_q[2:0]);
      end
      default: begin
        if (step_q[0]) begin
          xfer.nib        = cur_q.data[3:0];
          xfer.wait_after = cur_q.wait_after;
        end else begin
          xfer.nib         = cur_q.data[7:4];
          xfer.wait_before = cur_q.wait_before;
        end
      end
    endcase
  end

  assign xfer_last   = (step_q == total - 6'd1);
  assign load        = (state_q == B_RUN) && (!out_valid_q || out_ready_i);
  assign pop_ready_o = (state_q == B_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = B_RUN;
          step_d  = '0;
        end
      end
      B_RUN: begin
        if (load) begin
          step_d = step_q + 6'd1;
          if (xfer_last) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Current request and output payload
  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      cur_q <= pop_entry_i;
    end
    if (load) begin
      xfer_q <= xfer;
      last_q <= xfer_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign register_select_o = xfer_q.rs;
  assign nibble_o          = xfer_q.nib;
  assign wait_before_us_o  = xfer_q.wait_before;
  assign wait_after_us_o   = xfer_q.wait_after;
  assign last_o            = last_q;

`ifndef NO_ASSERTIONS
  // The final transfer releases the back end
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && xfer_last |=> state_q == B_IDLE)
    else $error("back end still busy after last transfer");

  // Step stays inside the request
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_RUN |-> step_q < total)
    else $error("transfer step out of range");

  // A new request starts at step zero
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_IDLE && pop_valid_i |=> state_q == B_RUN && step_q == '0)
    else $error("request did not start at first transfer");
`endif

endmodule

@@ rtl/char_lcd_nibble_write_sequencer.sv @@
// Top level of the character LCD 4-bit nibble write sequencer.
// Each request becomes the nibble transfers of a 4-bit character LCD bus, high nibble
// first: a command, character, cursor or clear request gives 2 transfers, init gives 8,
// and a number gives 2 per digit (up to 40); unknown kinds and zero-digit numbers give
// none. The front end registers each request and then offers it to the queue; a
// number first passes through the front end's one-bit-per-cycle binary to decimal
// shift loop. A two-entry request queue sits between front and back. The back end
// first registers a queued request, then emits one transfer per cycle while the
// output register is free.
module char_lcd_nibble_write_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  value_i,
  input  logic [5:0]  column_i,
  input  logic        row_i,
  input  logic [31:0] number_i,
  input  logic [4:0]  digit_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        register_select_o,
  output logic [3:0]  nibble_o,
  output logic [12:0] wait_before_us_o,
  output logic [12:0] wait_after_us_o,
  output logic        last_o
);
  import clnws_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_entry, pop_entry;

  // Request classification and decimal conversion
  clnws_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .number_i      (number_i),
    .digit_count_i (digit_count_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  // Request queue
  clnws_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Transfer sequencer
  clnws_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_entry_i       (pop_entry),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .register_select_o (register_select_o),
    .nibble_o          (nibble_o),
    .wait_before_us_o  (wait_before_us_o),
    .wait_after_us_o   (wait_after_us_o),
    .last_o            (last_o)
  );

endmodule
